// ===== hdl/cst_pkg.sv =====
// Types and character constants shared by the statement tokenizer.
package cst_pkg;

  typedef enum logic [2:0] {
    K_BYTE = 3'd0,
    K_EOW  = 3'd1,
    K_EOS  = 3'd2,
    K_DONE = 3'd3,
    K_ERR  = 3'd4
  } kind_t;

  typedef struct packed {
    logic between_words;
    logic in_comment;
    logic escape_pending;
    logic after_close_quote;
    logic in_double_quote;
    logic in_single_quote;
    logic statement_has_word;
  } tok_state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } res_t;

  localparam tok_state_t ST_RESET = '{between_words: 1'b1, default: 1'b0};

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_N  = 8'h6e;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

// ===== hdl/config_statement_tokenizer.sv =====
// Statement tokenizer: splits a byte stream into words and statements.
//
// Input channel: in_valid/in_stall carry one word per cycle when not stalled, either a body
// byte (in_mode 0, in_data_byte) or an end-of-body marker (in_mode 1).
// Result channel: out_valid/out_stall carry result words (out_kind, out_byte,
// out_last). An input word yields zero, one or two results; out_last marks
// the final one of each input word.
// Each result is written into the result queue when its input is accepted.
// Throughput: one input per cycle while the receiver keeps up, save for the
// stall below; the only per-cycle loop is the tokenizer flag update. A byte
// that yields two results writes both into the three-entry result queue.
// The input is stalled whenever fewer than two queue entries are free after
// this cycle's pop, so a stalled receiver holds one pending result while the
// next input is still taken, then back-pressures.
// Reset (rst_n low, synchronous) empties the queue and returns the tokenizer
// to its start state: between words, no statement open.
module config_statement_tokenizer
  import cst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_last
);

  tok_state_t state_r, state_nxt;
  res_t       queue_r [3];
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic [1:0] count_left;
  logic [1:0] res_n;
  kind_t      kind0, kind1;
  logic [7:0] data0, data1;
  logic       pop, acc;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  always_comb begin
    state_nxt = state_r;
    res_n     = 2'd0;
    kind0     = K_BYTE;
    kind1     = K_BYTE;
    data0     = 8'h00;
    data1     = 8'h00;
    if (in_mode) begin
      res_n     = 2'd1;
      kind0     = (state_r.statement_has_word || !state_r.between_words) ? K_ERR : K_DONE;
      state_nxt = ST_RESET;
    end else if (state_r.in_comment) begin
      if (in_data_byte == CH_LF) state_nxt.in_comment = 1'b0;
    end else if (state_r.escape_pending) begin
      state_nxt.escape_pending = 1'b0;
      res_n = 2'd1;
      case (in_data_byte)
        CH_DQUOTE, CH_SQUOTE, CH_BSLASH: data0 = in_data_byte;
        CH_LOW_T: data0 = CH_TAB;
        CH_LOW_R: data0 = CH_CR;
        CH_LOW_N: data0 = CH_LF;
        default: begin
          res_n = 2'd2;
          data0 = CH_BSLASH;
          data1 = in_data_byte;
        end
      endcase
    end else if (state_r.after_close_quote) begin
      if (is_ws(in_data_byte)) begin
        state_nxt.after_close_quote = 1'b0;
        state_nxt.between_words     = 1'b1;
      end else begin
        res_n     = 2'd1;
        kind0     = (in_data_byte == CH_SEMI) ? K_EOS : K_ERR;
        state_nxt = ST_RESET;
      end
    end else if (state_r.between_words) begin
      if (!is_ws(in_data_byte)) begin
        case (in_data_byte)
          CH_SEMI: begin
            res_n     = 2'd1;
            kind0     = state_r.statement_has_word ? K_EOS : K_ERR;
            state_nxt = ST_RESET;
          end
          CH_HASH: state_nxt.in_comment = 1'b1;
          CH_BSLASH: begin
            state_nxt.escape_pending = 1'b1;
            state_nxt.between_words  = 1'b0;
          end
          CH_DQUOTE: begin
            state_nxt.in_double_quote = 1'b1;
            state_nxt.between_words   = 1'b0;
          end
          CH_SQUOTE: begin
            state_nxt.in_single_quote = 1'b1;
            state_nxt.between_words   = 1'b0;
          end
          default: begin
            state_nxt.between_words = 1'b0;
            res_n = 2'd1;
            data0 = in_data_byte;
          end
        endcase
      end
    end else if (in_data_byte == CH_BSLASH) begin
      state_nxt.escape_pending = 1'b1;
    end else if (state_r.in_double_quote || state_r.in_single_quote) begin
      res_n = 2'd1;
      if (in_data_byte == (state_r.in_double_quote ? CH_DQUOTE : CH_SQUOTE)) begin
        state_nxt.in_double_quote    = 1'b0;
        state_nxt.in_single_quote    = 1'b0;
        state_nxt.after_close_quote  = 1'b1;
        state_nxt.statement_has_word = 1'b1;
        kind0 = K_EOW;
      end else begin
        data0 = in_data_byte;
      end
    end else if (is_ws(in_data_byte)) begin
      state_nxt.between_words      = 1'b1;
      state_nxt.statement_has_word = 1'b1;
      res_n = 2'd1;
      kind0 = K_EOW;
    end else if (in_data_byte == CH_SEMI) begin
      res_n     = 2'd2;
      kind0     = K_EOW;
      kind1     = K_EOS;
      state_nxt = ST_RESET;
    end else begin
      res_n = 2'd1;
      data0 = in_data_byte;
    end
  end

  assign out_valid  = (count_r != 2'd0);
  assign pop        = out_valid && !out_stall;
  assign count_left = count_r - {1'b0, pop};
  assign in_stall   = (count_left > 2'd1);
  assign acc        = in_valid && !in_stall;

  assign out_kind = queue_r[rd_ptr_r].kind;
  assign out_byte = queue_r[rd_ptr_r].data;
  assign out_last = queue_r[rd_ptr_r].last;

  always_comb begin
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    count_nxt  = count_left;
    if (acc) begin
      count_nxt = count_left + res_n;
      case (res_n)
        2'd1:    wr_ptr_nxt = ptr_inc(wr_ptr_r);
        2'd2:    wr_ptr_nxt = ptr_inc(ptr_inc(wr_ptr_r));
        default: wr_ptr_nxt = wr_ptr_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_RESET;
      rd_ptr_r <= 2'd0;
      wr_ptr_r <= 2'd0;
      count_r  <= 2'd0;
    end else begin
      if (acc) state_r <= state_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && (res_n != 2'd0)) begin
      queue_r[wr_ptr_r] <= '{kind: kind0, data: data0, last: (res_n == 2'd1)};
      if (res_n == 2'd2) begin
        queue_r[ptr_inc(wr_ptr_r)] <= '{kind: kind1, data: data1, last: 1'b1};
      end
    end
  end

  a_marker_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_mode |-> res_n == 2'd1)
    else $error("end-of-body marker must yield exactly one result");

  a_partner_queued: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> count_r >= 2'd2)
    else $error("non-final result without its partner in the queue");

  a_restart_after_mark: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (res_n != 2'd0) &&
    ((kind0 == K_ERR) || (kind0 == K_DONE) || (kind0 == K_EOS) || (kind1 == K_EOS))
    |=> state_r == ST_RESET)
    else $error("tokenizer did not restart after statement end, done or error");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r.in_comment && (state_r.escape_pending || state_r.in_double_quote ||
      state_r.in_single_quote || state_r.after_close_quote)))
    else $error("comment flag set together with a word flag");

endmodule

// ===== verif/config_statement_tokenizer_tb.sv =====
// Self-checking testbench for the statement tokenizer: random and directed byte streams.
import cst_pkg::*;

class token_tracker;
  res_t       expected_tokens[$];
  res_t       batch[$];
  tok_state_t st;
  int         n_checked;
  int         n_mismatch;

  function new();
    st = ST_RESET;
    n_checked = 0;
    n_mismatch = 0;
  endfunction

  function void add(kind_t k, logic [7:0] b);
    res_t r;
    r.kind = k;
    r.data = (k == K_BYTE) ? b : 8'h00;
    r.last = 1'b0;
    batch.push_back(r);
  endfunction

  function bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function void scan_byte(logic [7:0] c);
    logic [7:0] quote_ch;
    if (st.in_comment) begin
      if (c == CH_LF) st.in_comment = 1'b0;
      return;
    end
    if (st.escape_pending) begin
      st.escape_pending = 1'b0;
      if (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BSLASH) add(K_BYTE, c);
      else if (c == CH_LOW_T) add(K_BYTE, CH_TAB);
      else if (c == CH_LOW_R) add(K_BYTE, CH_CR);
      else if (c == CH_LOW_N) add(K_BYTE, CH_LF);
      else begin
        add(K_BYTE, CH_BSLASH);
        add(K_BYTE, c);
      end
      return;
    end
    if (st.after_close_quote) begin
      if (is_blank(c)) begin
        st.after_close_quote = 1'b0;
        st.between_words = 1'b1;
      end else begin
        add((c == CH_SEMI) ? K_EOS : K_ERR, 8'h00);
        st = ST_RESET;
      end
      return;
    end
    if (st.between_words) begin
      if (is_blank(c)) return;
      case (c)
        CH_SEMI: begin
          add(st.statement_has_word ? K_EOS : K_ERR, 8'h00);
          st = ST_RESET;
        end
        CH_HASH: st.in_comment = 1'b1;
        CH_BSLASH: begin
          st.escape_pending = 1'b1;
          st.between_words = 1'b0;
        end
        CH_DQUOTE: begin
          st.in_double_quote = 1'b1;
          st.between_words = 1'b0;
        end
        CH_SQUOTE: begin
          st.in_single_quote = 1'b1;
          st.between_words = 1'b0;
        end
        default: begin
          st.between_words = 1'b0;
          add(K_BYTE, c);
        end
      endcase
      return;
    end
    if (c == CH_BSLASH) begin
      st.escape_pending = 1'b1;
      return;
    end
    if (st.in_double_quote || st.in_single_quote) begin
      quote_ch = st.in_double_quote ? CH_DQUOTE : CH_SQUOTE;
      if (c == quote_ch) begin
        st.in_double_quote = 1'b0;
        st.in_single_quote = 1'b0;
        st.after_close_quote = 1'b1;
        st.statement_has_word = 1'b1;
        add(K_EOW, 8'h00);
      end else begin
        add(K_BYTE, c);
      end
      return;
    end
    if (is_blank(c)) begin
      st.between_words = 1'b1;
      st.statement_has_word = 1'b1;
      add(K_EOW, 8'h00);
    end else if (c == CH_SEMI) begin
      add(K_EOW, 8'h00);
      add(K_EOS, 8'h00);
      st = ST_RESET;
    end else begin
      add(K_BYTE, c);
    end
  endfunction

  function void note_input(logic mode, logic [7:0] c);
    batch.delete();
    if (mode) begin
      add((st.statement_has_word || !st.between_words) ? K_ERR : K_DONE, 8'h00);
      st = ST_RESET;
    end else begin
      scan_byte(c);
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) expected_tokens.push_back(batch[i]);
  endfunction

  function void check_token(logic [2:0] kind, logic [7:0] data, logic last);
    res_t want;
    n_checked++;
    if (expected_tokens.size() == 0) begin
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("mismatch %0d: result with nothing pending: kind=%0d byte=%02h last=%0b",
                 n_mismatch, kind, data, last);
      return;
    end
    want = expected_tokens.pop_front();
    if (want.kind !== kind || want.data !== data || want.last !== last) begin
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("mismatch %0d: expected kind=%0d byte=%02h last=%0b, %s",
                 n_mismatch, want.kind, want.data, want.last,
                 $sformatf("got kind=%0d byte=%02h last=%0b", kind, data, last));
    end
  endfunction
endclass

module config_statement_tokenizer_tb;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_PER_PHASE = 288;
  localparam logic [7:0] BLANKS [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
  localparam logic [7:0] ESC_CHARS [6] = '{CH_DQUOTE, CH_SQUOTE, CH_BSLASH,
                                           CH_LOW_T, CH_LOW_R, CH_LOW_N};
  // bit 8 set marks an end-of-body word
  localparam logic [8:0] OPENING [25] = '{
    9'h061, 9'h020, 9'h022, 9'h023, 9'h05c, 9'h06e, 9'h022, 9'h078,
    9'h03b,
    9'h05c, 9'h071, 9'h03b,
    9'h023, 9'h07a, 9'h00a, 9'h1ff,
    9'h027, 9'h0ff, 9'h05c, 9'h027, 9'h027, 9'h009, 9'h03b,
    9'h000, 9'h100
  };

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_mode = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;

  int idle_pct = 0;
  int stall_pct = 0;
  int item_count = 0;
  int statement_count = 0;
  int mark_count = 0;
  int cycle_count = 0;

  token_tracker tracker = new();

  config_statement_tokenizer DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) tracker.check_token(out_kind, out_byte, out_last);
      if (in_valid && !in_stall) tracker.note_input(in_mode, in_data_byte);
    end
  end

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
  end

  task automatic send_word(input logic m, input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    item_count++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(1'b0, b);
  endtask

  task automatic send_end_mark();
    send_word(1'b1, 8'($urandom_range(0, 255)));
    mark_count++;
  endtask

  function automatic logic [7:0] plain_char(bit opening);
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(128, 255))
                                      : 8'($urandom_range(33, 126));
    end while (c == CH_SEMI || c == CH_BSLASH ||
               (opening && (c == CH_HASH || c == CH_DQUOTE || c == CH_SQUOTE)));
    return c;
  endfunction

  task automatic send_escape();
    send_byte(CH_BSLASH);
    if ($urandom_range(0, 6) == 6) send_byte(8'($urandom_range(0, 255)));
    else send_byte(ESC_CHARS[$urandom_range(0, 5)]);
  endtask

  task automatic send_plain_word();
    int len;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) send_escape();
      else send_byte(plain_char(i == 0));
    end
  endtask

  task automatic send_quoted_word(input logic [7:0] q);
    int len;
    logic [7:0] c;
    len = $urandom_range(0, 5);
    send_byte(q);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        send_escape();
      end else begin
        do c = 8'($urandom_range(0, 255)); while (c == q || c == CH_BSLASH);
        send_byte(c);
      end
    end
    send_byte(q);
  endtask

  task automatic send_any_word();
    case ($urandom_range(0, 3))
      0, 1: send_plain_word();
      2: send_quoted_word(CH_DQUOTE);
      default: send_quoted_word(CH_SQUOTE);
    endcase
  endtask

  task automatic send_blank_run();
    repeat ($urandom_range(1, 2)) send_byte(BLANKS[$urandom_range(0, 3)]);
  endtask

  task automatic send_comment();
    logic [7:0] c;
    send_byte(CH_HASH);
    repeat ($urandom_range(0, 4)) begin
      do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
      send_byte(c);
    end
    send_byte(CH_LF);
  endtask

  task automatic send_statement();
    int nw;
    nw = $urandom_range(1, 4);
    if ($urandom_range(0, 7) == 0) send_comment();
    for (int i = 0; i < nw; i++) begin
      send_any_word();
      if (i == nw - 1) begin
        if ($urandom_range(0, 1)) send_blank_run();
        send_byte(CH_SEMI);
      end else begin
        send_blank_run();
        if ($urandom_range(0, 5) == 0) send_comment();
      end
    end
    statement_count++;
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1)) send_end_mark();
  endtask

  task automatic send_broken();
    case ($urandom_range(0, 4))
      0: send_byte(CH_SEMI);
      1: begin
        send_quoted_word($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
        send_byte(plain_char(1'b0));
      end
      2: begin
        send_any_word();
        send_end_mark();
      end
      3: begin
        send_byte(CH_DQUOTE);
        send_byte(plain_char(1'b0));
        send_end_mark();
      end
      default: begin
        send_byte(CH_HASH);
        send_byte(plain_char(1'b0));
        send_end_mark();
      end
    endcase
  endtask

  initial begin
    int r;
    int failures;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (OPENING[i]) send_word(OPENING[i][8], OPENING[i][7:0]);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      while (item_count < $size(OPENING) + (p + 1) * RANDOM_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 70) send_statement();
        else if (r < 78) send_end_mark();
        else if (r < 89) send_noise();
        else send_broken();
      end
    end

    in_valid <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    while (tracker.expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    failures = tracker.n_mismatch + tracker.expected_tokens.size();
    if (tracker.expected_tokens.size() != 0)
      $display("%0d expected results never arrived", tracker.expected_tokens.size());
    $display("Run covered %0d input words: %0d well-formed statements, %0d end markers,",
             item_count, statement_count, mark_count);
    $display("plus noise and broken input under four idle/stall mixes; %0d results compared.",
             tracker.n_checked);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
